// File: rtl/srm_pkg.sv
// Shared types, codes and the byte-to-table map of the substitute/rotate/mix unit.
package srm_pkg;

  localparam int NUM_LANES   = 8;
  localparam int TBL_SEL_W   = 3;
  localparam int ENTRY_W     = 8;
  localparam int MEM_ADDR_W  = TBL_SEL_W + ENTRY_W;
  localparam int WORD_W      = NUM_LANES * ENTRY_W;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PRISM = 2'd1,
    FUNC_ROLL  = 2'd2,
    FUNC_TURN  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    PAT_A1       = 3'd0,
    PAT_A4       = 3'd1,
    PAT_A8       = 3'd2,
    PAT_ABCD     = 3'd3,
    PAT_AABBCCDD = 3'd4,
    PAT_ABCDABCD = 3'd5,
    PAT_ABCDDCBA = 3'd6,
    PAT_ABCDEFGH = 3'd7
  } pattern_t;

  // How one byte lane is served under a pattern.
  typedef struct packed {
    logic                 sub;
    logic [TBL_SEL_W-1:0] tbl;
  } lane_map_t;

  // Control that travels with the lookup into the merge stage.
  typedef struct packed {
    logic                 valid;
    logic [NUM_LANES-1:0] sub_mask;
  } srm_ctl_t;

  function automatic lane_map_t lane_map(input pattern_t pat, input logic [2:0] lane);
    lane_map_t m;
    m.sub = 1'b1;
    m.tbl = '0;
    case (pat)
      PAT_A1:       m.sub = (lane == 3'd0);
      PAT_A4:       m.sub = ~lane[2];
      PAT_A8:       m.tbl = '0;
      PAT_ABCD: begin
        m.sub = ~lane[2];
        m.tbl = {1'b0, lane[1:0]};
      end
      PAT_AABBCCDD: m.tbl = {1'b0, lane[2:1]};
      PAT_ABCDABCD: m.tbl = {1'b0, lane[1:0]};
      PAT_ABCDDCBA: m.tbl = lane[2] ? {1'b0, ~lane[1:0]} : {1'b0, lane[1:0]};
      PAT_ABCDEFGH: m.tbl = lane;
      default:      m.tbl = '0;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/srm_lane.sv
// One byte lane: a private copy of all eight substitution tables with a registered read.
module srm_lane (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [srm_pkg::MEM_ADDR_W-1:0] wr_addr,
  input  logic [srm_pkg::ENTRY_W-1:0]    wr_data,
  input  logic [srm_pkg::MEM_ADDR_W-1:0] rd_addr,
  output logic [srm_pkg::ENTRY_W-1:0]    rd_data
);
  import srm_pkg::*;

  // Every lane receives every load, so each copy stays identical.
  logic [ENTRY_W-1:0] mem [1 << MEM_ADDR_W];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/srm_merge.sv
// Merge stage: picks substituted or passed bytes per lane, applies the XOR and registers the result.
module srm_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  srm_pkg::srm_ctl_t           ctl,
  input  logic [srm_pkg::WORD_W-1:0]  sub_word,
  input  logic [srm_pkg::WORD_W-1:0]  pass_word,
  input  logic [srm_pkg::WORD_W-1:0]  xor_word,
  output logic                        out_valid,
  output logic [srm_pkg::WORD_W-1:0]  out_mixed
);
  import srm_pkg::*;

  logic              valid_r;
  logic [WORD_W-1:0] mixed_r;
  logic [WORD_W-1:0] mixed_nxt;

  always_comb begin
    for (int b = 0; b < NUM_LANES; b++) begin
      mixed_nxt[b*ENTRY_W +: ENTRY_W] = ctl.sub_mask[b] ? sub_word[b*ENTRY_W +: ENTRY_W]
                                                        : pass_word[b*ENTRY_W +: ENTRY_W];
    end
    mixed_nxt = mixed_nxt ^ xor_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.valid;
    end
    mixed_r <= mixed_nxt;
  end

  assign out_valid = valid_r;
  assign out_mixed = mixed_r;

endmodule

// File: rtl/sbox_rotate_mix_unit.sv
// Top level of the substitute/rotate/mix unit: input decode, rotator, eight table lanes and merge.
//
// The unit takes one item in every clock cycle and never deasserts busy. A load
// item writes one byte into one of the eight 256-entry tables and gives no
// result; a mix item (prism, roll or turn) gives exactly one result on
// out_mixed, marked by out_valid, after the registered table read in each lane
// and the registered merge stage. Results appear in the order the items came in,
// and since the receiver cannot stall, each result is shown for one cycle only.
// A load takes effect for any mix item accepted after it, including the very
// next cycle. Table entries hold no defined value until written; a mix item
// that reads an unwritten entry returns an unspecified byte in that position.
module sbox_rotate_mix_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [2:0]                    in_pattern,
  input  logic [srm_pkg::WORD_W-1:0]    in_value,
  input  logic [5:0]                    in_rotate_amount,
  input  logic [srm_pkg::TBL_SEL_W-1:0] in_table_id,
  input  logic [srm_pkg::ENTRY_W-1:0]   in_entry_index,
  input  logic [srm_pkg::ENTRY_W-1:0]   in_entry_byte,
  output logic                          out_valid,
  output logic [srm_pkg::WORD_W-1:0]    out_mixed
);
  import srm_pkg::*;

  func_t    func;
  pattern_t pat;
  logic     accept;
  logic     load_en;
  logic     mix_en;

  // The pipeline has no back pressure, so the unit is always ready.
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign func    = func_t'(in_func);
  assign pat     = pattern_t'(in_pattern);
  assign load_en = accept && (func == FUNC_LOAD);
  assign mix_en  = accept && (func != FUNC_LOAD);

  // Left rotation: the upper half of the doubled word shifted left.
  logic [2*WORD_W-1:0] rot_wide;
  logic [WORD_W-1:0]   rot_word;
  logic [WORD_W-1:0]   lookup_word;

  assign rot_wide    = {in_value, in_value} << in_rotate_amount;
  assign rot_word    = rot_wide[2*WORD_W-1:WORD_W];
  // Turn substitutes the rotated word; prism and roll substitute the input word.
  assign lookup_word = (func == FUNC_TURN) ? rot_word : in_value;

  // Per-lane table selection and read addresses.
  logic [NUM_LANES-1:0]  sub_mask;
  logic [MEM_ADDR_W-1:0] rd_addr [NUM_LANES];
  logic [MEM_ADDR_W-1:0] wr_addr;

  always_comb begin
    lane_map_t m;
    for (int b = 0; b < NUM_LANES; b++) begin
      m           = lane_map(pat, 3'(b));
      sub_mask[b] = m.sub;
      rd_addr[b]  = {m.tbl, lookup_word[b*ENTRY_W +: ENTRY_W]};
    end
  end

  assign wr_addr = {in_table_id, in_entry_index};

  // Stage 1 registers run alongside the table reads.
  srm_ctl_t          ctl_r;
  srm_ctl_t          ctl_nxt;
  logic [WORD_W-1:0] pass_r;
  logic [WORD_W-1:0] xor_r;

  assign ctl_nxt.valid    = mix_en;
  assign ctl_nxt.sub_mask = sub_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    ctl_r.sub_mask <= ctl_nxt.sub_mask;
    pass_r         <= lookup_word;
    // Only roll folds the rotated word back in after substitution.
    xor_r          <= (func == FUNC_ROLL) ? rot_word : '0;
  end

  // Eight lanes, each with its own copy of the tables so all bytes read at once.
  logic [WORD_W-1:0] sub_word;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    srm_lane u_lane (
      .clk     (clk),
      .wr_en   (load_en),
      .wr_addr (wr_addr),
      .wr_data (in_entry_byte),
      .rd_addr (rd_addr[g]),
      .rd_data (sub_word[g*ENTRY_W +: ENTRY_W])
    );
  end

  srm_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_r),
    .sub_word  (sub_word),
    .pass_word (pass_r),
    .xor_word  (xor_r),
    .out_valid (out_valid),
    .out_mixed (out_mixed)
  );

endmodule
